[rtl/core/ps2m_pkg.sv]
// ----------------------------------------------------------------------------
// ps2m_pkg
// Shared types, codes and sizes for the mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2m_pkg;

  // Event queue: one slot stays empty, so it holds QUEUE_DEPTH-1 events
  localparam int QUEUE_DEPTH = 64;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Stream widths (whole bytes)
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 232;

  // Configuration register indexes
  localparam logic CFG_ENABLE     = 1'b0;
  localparam logic CFG_WHEEL_MODE = 1'b1;

  // Lead byte bit positions
  localparam int SYNC_BIT   = 3;
  localparam int X_SIGN     = 4;
  localparam int Y_SIGN     = 5;
  localparam int X_OVERFLOW = 6;
  localparam int Y_OVERFLOW = 7;

  // Last byte position of a packet in each mode
  localparam logic [1:0] LAST_POS_STD   = 2'd2;
  localparam logic [1:0] LAST_POS_WHEEL = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_INJECT = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  // One queued event; dx sits in the lowest bits (two's complement fields)
  typedef struct packed {
    logic [2:0] buttons;
    logic [8:0] scroll;
    logic [9:0] dy;
    logic [8:0] dx;
  } event_t;

  // Decoder verdict for the current word
  typedef struct packed {
    logic   take;
    logic   invalid;
    logic   overflow;
    event_t ev;
  } decode_out_t;

  // Reported status after a step
  typedef struct packed {
    logic [31:0] overflow_count;
    logic [31:0] invalid_count;
    logic [31:0] dropped_count;
    logic [31:0] received_count;
    logic [2:0]  buttons_now;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
  } status_t;

endpackage

[rtl/core/ps2m_ram.sv]
// ----------------------------------------------------------------------------
// ps2m_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ps2m_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ps2m_decode.sv]
// ----------------------------------------------------------------------------
// ps2m_decode
// Packet assembly, sync/overflow checks and event forming; holds config.
// ----------------------------------------------------------------------------
module ps2m_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic                  cfg_wdata,
  input  logic                  accept,
  input  ps2m_pkg::kind_t       kind,
  input  logic [7:0]            rx_byte,
  input  logic                  from_aux,
  input  logic [8:0]            inject_dx,
  input  logic [8:0]            inject_dy,
  input  logic [2:0]            inject_buttons,
  output ps2m_pkg::decode_out_t dec
);

  logic       enable;
  logic       wheel_mode;
  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] packet_bytes [3];
  logic       store_byte;
  logic [1:0] last_pos;
  logic [7:0] lead;
  logic [7:0] third;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      wheel_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ps2m_pkg::CFG_ENABLE:     enable     <= cfg_wdata;
        ps2m_pkg::CFG_WHEEL_MODE: wheel_mode <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Decode the current word
  always_comb begin
    last_pos           = wheel_mode ? ps2m_pkg::LAST_POS_WHEEL : ps2m_pkg::LAST_POS_STD;
    lead               = packet_bytes[0];
    // third byte may be arriving right now
    third              = (byte_position == 2'd2) ? rx_byte : packet_bytes[2];
    byte_position_next = byte_position;
    store_byte         = 1'b0;
    dec                = '0;
    unique case (kind)
      ps2m_pkg::KIND_BYTE: begin
        if (enable && from_aux) begin
          if (byte_position == 2'd0 && !rx_byte[ps2m_pkg::SYNC_BIT]) begin
            dec.invalid = 1'b1;
          end else begin
            store_byte = (byte_position != 2'd3);
            if (byte_position >= last_pos) begin
              byte_position_next = 2'd0;
              if (lead[ps2m_pkg::X_OVERFLOW] || lead[ps2m_pkg::Y_OVERFLOW]) begin
                dec.overflow = 1'b1;
              end else begin
                dec.take       = 1'b1;
                dec.ev.dx      = {lead[ps2m_pkg::X_SIGN], packet_bytes[1]};
                dec.ev.dy      = 10'd0 - {{2{lead[ps2m_pkg::Y_SIGN]}}, third};
                dec.ev.scroll  = wheel_mode ? (9'd0 - {rx_byte[7], rx_byte}) : 9'd0;
                dec.ev.buttons = lead[2:0];
              end
            end else begin
              byte_position_next = byte_position + 2'd1;
            end
          end
        end
      end
      ps2m_pkg::KIND_INJECT: begin
        dec.take       = 1'b1;
        dec.ev.dx      = inject_dx;
        dec.ev.dy      = {inject_dy[8], inject_dy};
        dec.ev.scroll  = 9'd0;
        dec.ev.buttons = inject_buttons;
      end
      ps2m_pkg::KIND_POP, ps2m_pkg::KIND_STATUS: ;
      default: ;
    endcase
  end

  // Advance byte position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 2'd0;
    end else if (accept) begin
      byte_position <= byte_position_next;
    end
  end

  // Capture packet bytes
  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      packet_bytes[byte_position] <= rx_byte;
    end
  end

  // A rejected lead byte leaves the packet unstarted
  a_invalid_restart: assert property (@(posedge clk) disable iff (rst)
    accept && dec.invalid |=> byte_position == 2'd0)
    else $error("byte position moved after a missing sync bit");

endmodule

[rtl/core/ps2m_queue.sv]
// ----------------------------------------------------------------------------
// ps2m_queue
// Event FIFO over a synchronous RAM; one push or one pop per word.
// ----------------------------------------------------------------------------
module ps2m_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             push,
  input  ps2m_pkg::event_t push_ev,
  input  logic             pop,
  output logic             pop_hit,
  output logic             drop_hit,
  output ps2m_pkg::event_t pop_ev
);

  localparam logic [ps2m_pkg::QPTR_W-1:0] PTR_LAST =
    ps2m_pkg::QPTR_W'(ps2m_pkg::QUEUE_DEPTH - 1);

  logic [ps2m_pkg::QPTR_W-1:0] write_pointer;
  logic [ps2m_pkg::QPTR_W-1:0] read_pointer;
  logic [ps2m_pkg::QPTR_W-1:0] wp_inc;
  logic [ps2m_pkg::QPTR_W-1:0] rp_inc;
  logic                        full;
  logic                        empty;
  logic                        ram_we;
  logic                        ram_re;

  // Pointer arithmetic and flags
  always_comb begin
    wp_inc   = (write_pointer == PTR_LAST) ? '0 : write_pointer + 1'b1;
    rp_inc   = (read_pointer == PTR_LAST) ? '0 : read_pointer + 1'b1;
    full     = (wp_inc == read_pointer);
    empty    = (write_pointer == read_pointer);
    drop_hit = push && full;
    pop_hit  = pop && !empty;
    ram_we   = accept && push && !full;
    ram_re   = accept && pop_hit;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
    end else begin
      if (ram_we) begin
        write_pointer <= wp_inc;
      end
      if (ram_re) begin
        read_pointer <= rp_inc;
      end
    end
  end

  // A pop reads only entries written in earlier cycles, so no bypass is needed
  ps2m_ram #(
    .DEPTH (ps2m_pkg::QUEUE_DEPTH),
    .WIDTH ($bits(ps2m_pkg::event_t)),
    .ADDR_W(ps2m_pkg::QPTR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_pointer),
    .wdata(push_ev),
    .re   (ram_re),
    .raddr(read_pointer),
    .rdata(pop_ev)
  );

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    ram_we |=> write_pointer != read_pointer)
    else $error("queue empty right after a push");

  a_drop_holds: assert property (@(posedge clk) disable iff (rst)
    accept && drop_hit |=> $stable(write_pointer) && $stable(read_pointer))
    else $error("pointers moved on a dropped event");

endmodule

[rtl/core/ps2_mouse_packet_decoder.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Mouse byte stream to movement events, with event queue and status counters.
// ----------------------------------------------------------------------------
//  channel  direction  tvalid/tready/we   payload
//  s_*      in         s_tvalid/s_tready  tuser: kind; tdata: byte and inject
//  m_*      out        m_tvalid/m_tready  tuser: event_valid; tdata: event+status
//  cfg_*    in         cfg_we             cfg_addr: register, cfg_wdata: value
//
// One word accepted per cycle while s_tready is high. The accepting edge updates
// state and launches the event RAM read; the output register then loads from
// the middle stage once it may move, which raises m_tvalid.
// Reset clears the state registers; the event RAM needs no clearing pass.
// With m_tready low the block still takes one more word into its middle stage,
// then holds s_tready low until the output register drains.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_decoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic                             cfg_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // rx_byte[7:0], from_aux[8], inject_dx[17:9], inject_dy[26:18],
  // inject_buttons[29:27], zero fill[31:30]
  input  logic [ps2m_pkg::IN_TDATA_W-1:0]  s_tdata,
  // kind[1:0]
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // event_dx[8:0], event_dy[18:9], event_scroll[27:19], event_buttons[30:28],
  // pos_x[62:31], pos_y[94:63], buttons_now[97:95], received_count[129:98],
  // dropped_count[161:130], invalid_count[193:162], overflow_count[225:194],
  // zero fill[231:226]
  output logic [ps2m_pkg::OUT_TDATA_W-1:0] m_tdata,
  // event_valid[0]
  output logic                             m_tuser
);

  logic                  accept;
  ps2m_pkg::kind_t       kind;
  ps2m_pkg::decode_out_t dec;
  logic                  pop_hit;
  logic                  drop_hit;
  ps2m_pkg::event_t      pop_ev;
  ps2m_pkg::status_t     status;
  ps2m_pkg::status_t     status_next;
  logic                  st1_valid;
  logic                  st1_ev_valid;
  ps2m_pkg::status_t     st1_status;
  logic                  st1_move;
  ps2m_pkg::event_t      out_ev;

  assign kind     = ps2m_pkg::kind_t'(s_tuser);
  assign st1_move = !m_tvalid || m_tready;
  assign s_tready = !st1_valid || st1_move;
  assign accept   = s_tvalid && s_tready;

  ps2m_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .accept        (accept),
    .kind          (kind),
    .rx_byte       (s_tdata[7:0]),
    .from_aux      (s_tdata[8]),
    .inject_dx     (s_tdata[17:9]),
    .inject_dy     (s_tdata[26:18]),
    .inject_buttons(s_tdata[29:27]),
    .dec           (dec)
  );

  ps2m_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .push    (dec.take),
    .push_ev (dec.ev),
    .pop     (kind == ps2m_pkg::KIND_POP),
    .pop_hit (pop_hit),
    .drop_hit(drop_hit),
    .pop_ev  (pop_ev)
  );

  // Position, buttons and counters after this word
  always_comb begin
    status_next = status;
    if (dec.take) begin
      status_next.pos_x          = status.pos_x + {{23{dec.ev.dx[8]}}, dec.ev.dx};
      status_next.pos_y          = status.pos_y + {{22{dec.ev.dy[9]}}, dec.ev.dy};
      status_next.buttons_now    = dec.ev.buttons;
      status_next.received_count = status.received_count + 32'd1;
    end
    if (drop_hit) begin
      status_next.dropped_count = status.dropped_count + 32'd1;
    end
    if (dec.invalid) begin
      status_next.invalid_count = status.invalid_count + 32'd1;
    end
    if (dec.overflow) begin
      status_next.overflow_count = status.overflow_count + 32'd1;
    end
  end

  // Hold status state
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
    end else if (accept) begin
      status <= status_next;
    end
  end

  // Middle stage: waits for the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      st1_valid <= 1'b0;
    end else if (accept) begin
      st1_valid <= 1'b1;
    end else if (st1_move) begin
      st1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st1_ev_valid <= pop_hit;
      st1_status   <= status_next;
    end
  end

  // Output register
  assign out_ev = st1_ev_valid ? pop_ev : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (st1_move) begin
      m_tvalid <= st1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (st1_move && st1_valid) begin
      m_tuser <= st1_ev_valid;
      m_tdata <= {6'd0, st1_status, out_ev};
    end
  end

  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[30:0] == '0)
    else $error("event fields nonzero without a popped event");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> st1_valid && m_tvalid)
    else $error("input stalled with a free stage");

endmodule
